// ----- sv/lookup2_string_hash_top_defines.svh -----
// ----------------------------------------------------------------------------
// lookup2 string hash: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef LOOKUP2_STRING_HASH_TOP_DEFINES_SVH
`define LOOKUP2_STRING_HASH_TOP_DEFINES_SVH

// same-cycle implication
`define LSH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define LSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/lsh_pkg.sv -----
// ----------------------------------------------------------------------------
// lsh_pkg
// Types, constants and the mix round shared by the lookup2 hash modules.
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
  localparam int          BLOCK_BYTES  = 12;
  localparam logic [3:0]  LAST_POS     = 4'(BLOCK_BYTES - 1);
  localparam logic [3:0]  LAST_ROW     = 4'd8;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lanes_t;

  // One queue entry: an optional block fold and an optional final fold.
  typedef struct packed {
    logic        start;     // reload lanes before folding
    logic [31:0] seed;
    logic        do_block;
    lanes_t      blk;
    logic        do_final;
    lanes_t      tail;      // tail.c already holds the key length
  } job_t;

  function automatic lanes_t lane_add(lanes_t x, lanes_t y);
    lanes_t r;
    r.a = x.a + y.a;
    r.b = x.b + y.b;
    r.c = x.c + y.c;
    return r;
  endfunction

  // One row of the mix: two subtracts and a shifted xor on one lane.
  function automatic lanes_t mix_row(lanes_t l, logic [3:0] row);
    lanes_t r;
    r = l;
    case (row)
      4'd0: r.a = (l.a - l.b - l.c) ^ (l.c >> 13);
      4'd1: r.b = (l.b - l.c - l.a) ^ (l.a << 8);
      4'd2: r.c = (l.c - l.a - l.b) ^ (l.b >> 13);
      4'd3: r.a = (l.a - l.b - l.c) ^ (l.c >> 12);
      4'd4: r.b = (l.b - l.c - l.a) ^ (l.a << 16);
      4'd5: r.c = (l.c - l.a - l.b) ^ (l.b >> 5);
      4'd6: r.a = (l.a - l.b - l.c) ^ (l.c >> 3);
      4'd7: r.b = (l.b - l.c - l.a) ^ (l.a << 10);
      4'd8: r.c = (l.c - l.a - l.b) ^ (l.b >> 15);
      default: r = l;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/lsh_front.sv -----
// ----------------------------------------------------------------------------
// lsh_front
// Collects key bytes into a 12-byte block and posts fold jobs to the queue.
// ----------------------------------------------------------------------------
module lsh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        seed,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] key_byte
  input  logic               s_tuser,   // [0] byte_present
  input  logic               s_tlast,   // last_byte
  input  logic               q_full,
  output logic               push,
  output lsh_pkg::job_t      push_job
);

  logic        mid_key;
  logic        pend_start;
  logic [31:0] seed_hold;
  logic [3:0]  pos;
  logic [31:0] len;
  logic [7:0]  blk_byte [0:10];

  logic        accept;
  logic        active;
  logic        start;
  logic        present;
  logic        blk_done;
  logic [3:0]  pos_cur;
  logic [3:0]  pos_after;
  logic [31:0] len_new;
  logic [7:0]  eff [0:11];
  logic [7:0]  tb  [0:10];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign present  = s_tuser;
  assign active   = accept && (present || s_tlast);
  assign start    = !mid_key;
  assign pos_cur  = start ? 4'd0 : pos;
  assign len_new  = (start ? 32'd0 : len) + 32'(present);
  assign blk_done = present && (pos_cur == lsh_pkg::LAST_POS);
  assign pos_after = blk_done ? 4'd0 : pos_cur + 4'(present);

  always_comb begin
    for (int k = 0; k < 11; k++) begin
      eff[k] = (present && pos_cur == 4'(k)) ? s_tdata : blk_byte[k];
      tb[k]  = (4'(k) < pos_after) ? eff[k] : 8'h00;
    end
    eff[11] = s_tdata;
  end

  always_comb begin
    push_job          = '0;
    push_job.start    = start || pend_start;
    push_job.seed     = start ? seed : seed_hold;
    push_job.do_block = blk_done;
    push_job.blk.a    = {eff[3], eff[2], eff[1], eff[0]};
    push_job.blk.b    = {eff[7], eff[6], eff[5], eff[4]};
    push_job.blk.c    = {eff[11], eff[10], eff[9], eff[8]};
    push_job.do_final = s_tlast;
    push_job.tail.a   = {tb[3], tb[2], tb[1], tb[0]};
    push_job.tail.b   = {tb[7], tb[6], tb[5], tb[4]};
    // c-lane tail bytes sit one byte up, low byte left free
    push_job.tail.c   = len_new + {tb[10], tb[9], tb[8], 8'h00};
  end

  assign push = active && (blk_done || s_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_key    <= 1'b0;
      pend_start <= 1'b0;
      pos        <= 4'd0;
      len        <= 32'd0;
    end else if (active) begin
      mid_key    <= !s_tlast;
      pos        <= s_tlast ? 4'd0 : pos_after;
      len        <= s_tlast ? 32'd0 : len_new;
      // hold the reload request until the key's first job goes out
      pend_start <= push ? 1'b0 : (start || pend_start);
    end
  end

  always_ff @(posedge clk) begin
    if (active && start) begin
      seed_hold <= seed;
    end
    if (active && present && pos_cur != lsh_pkg::LAST_POS) begin
      blk_byte[pos_cur] <= s_tdata;
    end
  end

endmodule

// ----- sv/lsh_queue.sv -----
// ----------------------------------------------------------------------------
// lsh_queue
// Small job queue between the byte collector and the mix engine.
// ----------------------------------------------------------------------------
`include "lookup2_string_hash_top_defines.svh"

module lsh_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lsh_pkg::job_t      push_job,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output lsh_pkg::job_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lsh_pkg::job_t    slot [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  `LSH_ASSERT_IMPL(a_no_push_full, full, !push)
  `LSH_ASSERT_IMPL(a_no_pop_empty, pop, q_valid)

endmodule

// ----- sv/lsh_back.sv -----
// ----------------------------------------------------------------------------
// lsh_back
// Mix engine: folds queued words into the lanes and runs the mix, one row a
// cycle, then registers the final c lane as the hash when m_* is free.
// ----------------------------------------------------------------------------
`include "lookup2_string_hash_top_defines.svh"

module lsh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  lsh_pkg::job_t      head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata    // [31:0] hash_value
);

  localparam logic ST_BLOCK = 1'b0;
  localparam logic ST_FINAL = 1'b1;

  logic              busy;
  logic              stage;
  logic [3:0]        row;
  lsh_pkg::lanes_t   lanes;
  lsh_pkg::lanes_t   base;
  lsh_pkg::lanes_t   mixed;
  logic              out_free;
  logic              last_row;
  logic              out_load;

  assign out_free = !m_tvalid || m_tready;
  assign last_row = (row == lsh_pkg::LAST_ROW);
  assign mixed    = lsh_pkg::mix_row(lanes, row);
  assign out_load = busy && last_row && stage == ST_FINAL && out_free;

  always_comb begin
    base = lanes;
    if (head.start) begin
      base.a = lsh_pkg::GOLDEN_RATIO;
      base.b = lsh_pkg::GOLDEN_RATIO;
      base.c = head.seed;
    end
  end

  assign pop = busy && last_row &&
               ((stage == ST_BLOCK && !head.do_final) || (stage == ST_FINAL && out_free));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      stage    <= ST_BLOCK;
      row      <= 4'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (!busy) begin
        if (q_valid) begin
          busy  <= 1'b1;
          row   <= 4'd0;
          stage <= head.do_block ? ST_BLOCK : ST_FINAL;
        end
      end else if (!last_row) begin
        row <= row + 4'd1;
      end else if (stage == ST_BLOCK) begin
        if (head.do_final) begin
          stage <= ST_FINAL;
          row   <= 4'd0;
        end else begin
          busy <= 1'b0;
        end
      end else if (out_free) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      if (q_valid) begin
        lanes <= head.do_block ? lsh_pkg::lane_add(base, head.blk)
                               : lsh_pkg::lane_add(base, head.tail);
      end
    end else if (!last_row) begin
      lanes <= mixed;
    end else if (stage == ST_BLOCK) begin
      lanes <= head.do_final ? lsh_pkg::lane_add(mixed, head.tail) : mixed;
    end else if (out_free) begin
      lanes   <= mixed;
      m_tdata <= mixed.c;
    end
  end

  `LSH_ASSERT_IMPL(a_row_bound, busy, row <= lsh_pkg::LAST_ROW)
  `LSH_ASSERT_NEXT(a_final_loads_out, busy && stage == ST_FINAL && last_row && out_free,
                   m_tvalid && !busy)

endmodule

// ----- sv/lookup2_string_hash_top.sv -----
// ----------------------------------------------------------------------------
// lookup2_string_hash_top
// Byte-serial 32-bit lookup2 hash with a seed register.
//
//   channel  dir  fields                                      accepted when
//   s_*      in   tdata[7:0] key_byte, tuser byte_present,    s_tvalid & s_tready
//                 tlast last_byte
//   m_*      out  tdata[31:0] hash_value                      m_tvalid & m_tready
//   apb      in   reg 0 @ 0x0: initial_value[31:0]            psel&penable&pwrite
//
// One key byte is taken per cycle while the job queue has room.
// The mix engine runs one mix row per cycle, holding the last row of a final
// fold until m_* is free; a 12-byte block and a final fold each run the full
// mix, one job at a time, so short keys are limited by the mix engine.
// rst is synchronous and clears all control state; the seed resets to zero.
// A held m_tready backs up the queue and then s_tready; the hash output is a
// register, so the engine keeps working on queued blocks meanwhile.
// ----------------------------------------------------------------------------
module lookup2_string_hash_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] key_byte
  input  logic        s_tuser,    // [0] byte_present
  input  logic        s_tlast,    // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] hash_value
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic ADDR_SEED = 1'b0;

  logic               [31:0] seed;
  logic                      q_full;
  logic                      push;
  logic                      pop;
  logic                      q_valid;
  lsh_pkg::job_t             push_job;
  lsh_pkg::job_t             head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_SEED) ? seed : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'h0;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_SEED) begin
      seed <= pwdata;
    end
  end

  lsh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .seed     (seed),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  lsh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  lsh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- tb/lookup2_string_hash_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lookup2_string_hash_checker
// Watches the key stream, the seed register port and the hash stream. It
// keeps its own lane state, computes the hash of each key as its final item
// goes in, and compares every hash that comes out against the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module lookup2_string_hash_checker #(
  parameter logic [2:0] SEED_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] key_byte
  input  logic        s_tuser,    // [0] byte_present
  input  logic        s_tlast,    // last_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,    // [31:0] hash_value
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count,
  output int          hash_count
);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lane_set_t;

  logic [31:0] seed_reg;
  lane_set_t   lanes;
  logic [7:0]  block_buf [lsh_pkg::BLOCK_BYTES];
  int          block_pos;
  logic [31:0] key_len;
  logic        in_key;
  logic [31:0] expected_hashes [$];
  int          errors;
  int          checked;

  function automatic lane_set_t mix_lanes(lane_set_t l);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = l.a;
    b = l.b;
    c = l.c;
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
    return {a, b, c};
  endfunction

  function automatic logic [31:0] block_word(int base);
    return {block_buf[base + 3], block_buf[base + 2], block_buf[base + 1], block_buf[base]};
  endfunction

  // Advance the hash state by one key item; returns 1 with the hash when the key ends.
  function automatic bit absorb_item(logic [7:0] kb, logic pres, logic lst,
                                     output logic [31:0] hash);
    hash = '0;
    if (!pres && !lst) return 1'b0;
    if (!in_key) begin
      lanes     = {lsh_pkg::GOLDEN_RATIO, lsh_pkg::GOLDEN_RATIO, seed_reg};
      block_pos = 0;
      key_len   = '0;
      in_key    = 1'b1;
    end
    if (pres) begin
      block_buf[block_pos] = kb;
      block_pos++;
      key_len++;
      if (block_pos == lsh_pkg::BLOCK_BYTES) begin
        lanes.a += block_word(0);
        lanes.b += block_word(4);
        lanes.c += block_word(8);
        lanes = mix_lanes(lanes);
        block_pos = 0;
      end
    end
    if (!lst) return 1'b0;
    lanes.c += key_len;
    // c-lane tail bytes sit one byte up, low byte left free
    for (int i = 0; i < block_pos && i < lsh_pkg::BLOCK_BYTES - 1; i++) begin
      if (i < 4)
        lanes.a += 32'(block_buf[i]) << (8 * i);
      else if (i < 8)
        lanes.b += 32'(block_buf[i]) << (8 * (i - 4));
      else
        lanes.c += 32'(block_buf[i]) << (8 * (i - 7));
    end
    lanes     = mix_lanes(lanes);
    hash      = lanes.c;
    in_key    = 1'b0;
    block_pos = 0;
    key_len   = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    logic [31:0] hv;
    logic [31:0] want;
    bit          got;
    if (rst) begin
      seed_reg  = '0;
      in_key    = 1'b0;
      block_pos = 0;
      key_len   = '0;
      errors    = 0;
      checked   = 0;
      expected_hashes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value: expected none, actual %08h", m_tdata);
          errors++;
        end else begin
          want = expected_hashes.pop_front();
          if (m_tdata !== want) begin
            $error("hash_value: expected %08h, actual %08h", want, m_tdata);
            errors++;
          end
          checked++;
        end
      end
      if (psel && penable && !pwrite && pready && paddr == SEED_ADDR &&
          prdata !== seed_reg) begin
        $error("initial_value: expected %08h, actual %08h", seed_reg, prdata);
        errors++;
      end
      if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
        seed_reg = pwdata;
      if (s_tvalid && s_tready) begin
        got = absorb_item(s_tdata, s_tuser, s_tlast, hv);
        if (got) expected_hashes.push_back(hv);
      end
    end
    fail_count    <= errors;
    hash_count    <= checked;
    pending_count <= expected_hashes.size();
  end

endmodule

// ----- tb/tb_lookup2_string_hash_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lookup2_string_hash_top
// Streams keys of assorted lengths into the hash block under several seeds
// and idle patterns; the checker beside the block predicts and compares each
// hash, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_lookup2_string_hash_top;

  localparam logic [2:0] SEED_ADDR       = 3'd0;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         DRAIN_CYCLES    = 40;
  localparam int         ITEMS_PER_PHASE = 410;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_count;
  int hash_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int keys_sent      = 0;
  int seeds_written  = 0;
  int cycle_count    = 0;

  lookup2_string_hash_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lookup2_string_hash_checker #(.SEED_ADDR(SEED_ADDR)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .hash_count    (hash_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom());
  endfunction

  task automatic send_item(logic [7:0] kb, logic pres, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= kb;
    s_tuser  <= pres;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Bytes with a sprinkle of absent items; optionally close with an absent last item.
  task automatic send_key(int len, bit absent_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(pick_byte(), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, !absent_end && i == len - 1);
    end
    if (len == 0 || absent_end) send_item(pick_byte(), 1'b0, 1'b1);
    keys_sent++;
  endtask

  task automatic apb_access(logic wr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SEED_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
    seeds_written++;
  endtask

  // Drop valid and wait for every hash, then for the engine to go quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, logic [31:0] seed);
    int start;
    int r;
    int len;
    settle();
    write_seed(seed);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < ITEMS_PER_PHASE) begin
      r = $urandom_range(99);
      if (r < 70)
        len = $urandom_range(14);
      else if (r < 95)
        len = $urandom_range(40, 15);
      else
        len = $urandom_range(64, 41);
      send_key(len, $urandom_range(4) == 0);
    end
  endtask

  initial begin : timeout
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lookup2_string_hash_top verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_seed(32'h0000_0000);

    // empty key, then a one-byte key
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    // absent item outside a key does nothing
    send_item(8'hff, 1'b0, 1'b0);
    // final byte closes a whole block, leaving an empty tail
    for (int i = 0; i < 12; i++)
      send_item((i % 2) ? 8'hff : 8'h00, 1'b1, i == 11);
    // key ended by an absent last item
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    keys_sent += 4;

    run_phase(0, 0, 32'hffff_ffff);
    run_phase(53, 0, $urandom());
    run_phase(0, 53, $urandom());
    run_phase(15, 15, 32'h0000_0000);
    settle();

    $display("Ran %0d input items in %0d keys under %0d seed settings; %0d hashes compared.",
             items_sent, keys_sent, seeds_written, hash_count);
    if (fail_count == 0) begin
      $display("lookup2_string_hash_top verification clean");
    end else begin
      $display("lookup2_string_hash_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/lsh_pkg.sv
sv/lsh_front.sv
sv/lsh_queue.sv
sv/lsh_back.sv
sv/lookup2_string_hash_top.sv
tb/lookup2_string_hash_checker.sv
tb/tb_lookup2_string_hash_top.sv
